// File: design/iuv_pkg.sv
// shared types and constants for the identifier utf-8 validator
// used by iuv_step and identifier_utf8_validator; no dependencies
package iuv_pkg;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_EMPTY    = 3'd1;
    localparam logic [2:0] ST_UTF8     = 3'd2;
    localparam logic [2:0] ST_CONTROL  = 3'd3;
    localparam logic [2:0] ST_RESERVED = 3'd4;

    localparam logic [2:0] LK_NONE = 3'd0;
    localparam logic [2:0] LK_E0   = 3'd1;
    localparam logic [2:0] LK_ED   = 3'd2;
    localparam logic [2:0] LK_F0   = 3'd3;
    localparam logic [2:0] LK_F4   = 3'd4;

    localparam logic [2:0] NAME_SAT = 3'd5;
    localparam logic [2:0] WORD_LEN = 3'd4;

    typedef struct packed {
        logic [1:0] pending;
        logic [2:0] lead_kind;
        logic       expect_second;
        logic       utf8_bad;
        logic       control_bad;
        logic       prev_c2;
        logic [1:0] bom_stage;
        logic [2:0] name_len;
        logic       reserved_match;
    } t_state;

    localparam t_state STATE_RESET = '{
        pending:        2'd0,
        lead_kind:      LK_NONE,
        expect_second:  1'b0,
        utf8_bad:       1'b0,
        control_bad:    1'b0,
        prev_c2:        1'b0,
        bom_stage:      2'd0,
        name_len:       3'd0,
        reserved_match: 1'b1
    };

    // lower-case letters of the reserved word "time"
    function automatic logic [7:0] reserved_char(input logic [1:0] idx);
        logic [7:0] c;
        case (idx)
            2'd0:    c = 8'h74;
            2'd1:    c = 8'h69;
            2'd2:    c = 8'h6D;
            default: c = 8'h65;
        endcase
        return c;
    endfunction

    function automatic logic second_byte_ok(input logic [2:0] kind, input logic [7:0] b);
        logic ok;
        unique case (kind)
            LK_E0:   ok = (b >= 8'hA0);
            LK_ED:   ok = (b <= 8'h9F);
            LK_F0:   ok = (b >= 8'h90);
            LK_F4:   ok = (b <= 8'h8F);
            default: ok = 1'b1;
        endcase
        return ok;
    endfunction

endpackage

// File: design/iuv_step.sv
// next-state and status logic for one byte of an identifier
// depends on iuv_pkg
module iuv_step
    import iuv_pkg::*;
(
    input  t_state     i_state,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    input  logic       i_empty_name,
    output t_state     o_state,
    output logic       o_result,
    output logic [2:0] o_status
);

    t_state     s;
    logic [7:0] low;

    always_comb begin
        s = i_state;

        // utf-8 sequence decode
        if (i_state.pending != 2'd0) begin
            if (i_data_byte < 8'h80 || i_data_byte > 8'hBF) begin
                s.utf8_bad = 1'b1;
                s.pending  = 2'd0;
            end else begin
                if (i_state.expect_second &&
                    !second_byte_ok(i_state.lead_kind, i_data_byte)) begin
                    s.utf8_bad = 1'b1;
                end
                s.pending = i_state.pending - 2'd1;
            end
            s.expect_second = 1'b0;
            s.lead_kind     = LK_NONE;
        end else if (i_data_byte <= 8'h7F) begin
            s.pending = 2'd0;
        end else if (i_data_byte >= 8'hC2 && i_data_byte <= 8'hDF) begin
            s.pending       = 2'd1;
            s.lead_kind     = LK_NONE;
            s.expect_second = 1'b1;
        end else if (i_data_byte >= 8'hE0 && i_data_byte <= 8'hEF) begin
            s.pending       = 2'd2;
            s.lead_kind     = (i_data_byte == 8'hE0) ? LK_E0 :
                              (i_data_byte == 8'hED) ? LK_ED : LK_NONE;
            s.expect_second = 1'b1;
        end else if (i_data_byte >= 8'hF0 && i_data_byte <= 8'hF4) begin
            s.pending       = 2'd3;
            s.lead_kind     = (i_data_byte == 8'hF0) ? LK_F0 :
                              (i_data_byte == 8'hF4) ? LK_F4 : LK_NONE;
            s.expect_second = 1'b1;
        end else begin
            s.utf8_bad = 1'b1;
        end

        // byte order mark EF BB BF
        if (i_state.bom_stage == 2'd2 && i_data_byte == 8'hBF) begin
            s.utf8_bad  = 1'b1;
            s.bom_stage = 2'd0;
        end else if (i_state.bom_stage == 2'd1 && i_data_byte == 8'hBB) begin
            s.bom_stage = 2'd2;
        end else begin
            s.bom_stage = (i_data_byte == 8'hEF) ? 2'd1 : 2'd0;
        end

        // c0, del and c1 (c2 80..9f)
        if (i_data_byte < 8'h20 || i_data_byte == 8'h7F) begin
            s.control_bad = 1'b1;
        end
        if (i_state.prev_c2 && i_data_byte >= 8'h80 && i_data_byte <= 8'h9F) begin
            s.control_bad = 1'b1;
        end
        s.prev_c2 = (i_data_byte == 8'hC2);

        // reserved word, ascii case folded
        low = (i_data_byte >= 8'h41 && i_data_byte <= 8'h5A) ?
              (i_data_byte | 8'h20) : i_data_byte;
        if (i_state.name_len < WORD_LEN) begin
            if (low != reserved_char(i_state.name_len[1:0])) begin
                s.reserved_match = 1'b0;
            end
        end else begin
            s.reserved_match = 1'b0;
        end
        if (i_state.name_len < NAME_SAT) begin
            s.name_len = i_state.name_len + 3'd1;
        end

        // cut-off sequence at the end of the name
        if (i_last_byte && s.pending != 2'd0) begin
            s.utf8_bad = 1'b1;
        end

        if (s.utf8_bad) begin
            o_status = ST_UTF8;
        end else if (s.control_bad) begin
            o_status = ST_CONTROL;
        end else if (s.reserved_match && s.name_len == WORD_LEN) begin
            o_status = ST_RESERVED;
        end else begin
            o_status = ST_OK;
        end

        o_result = i_last_byte || i_empty_name;
        o_state  = s;
        if (i_empty_name) begin
            o_status = ST_EMPTY;
        end
        if (o_result) begin
            o_state = STATE_RESET;
        end
    end

endmodule

// File: design/identifier_utf8_validator.sv
// top level of the identifier utf-8 validator: input register, state, result register
// depends on iuv_pkg and iuv_step
//
// Checks the bytes of one identifier, one byte per transaction, and gives one
// status transaction when the final byte (or an empty-name marker) arrives:
// 0 ok, 1 empty, 2 invalid strict UTF-8 or byte order mark, 3 control
// character, 4 the reserved name "time" in any ASCII case. Empty has the highest
// priority, then 2, 3 and 4. A byte is taken every cycle while o_stall is low; the
// per-byte work sits between the input register and the state and result
// registers, so a status enters the result register when its final byte leaves
// the input register. A stall on the result side holds only transactions that
// end a name; plain bytes keep flowing until the next final byte meets a full result register.
module identifier_utf8_validator
    import iuv_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    input  logic       i_empty_name,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [2:0] o_status
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic       r_in_empty;
    t_state     r_state;
    logic       r_out_valid;
    logic [2:0] r_out_status;

    t_state     n_state;
    logic       step_result;
    logic [2:0] step_status;
    logic       out_free;
    logic       fire;

    iuv_step u_step (
        .i_state      (r_state),
        .i_data_byte  (r_in_byte),
        .i_last_byte  (r_in_last),
        .i_empty_name (r_in_empty),
        .o_state      (n_state),
        .o_result     (step_result),
        .o_status     (step_status)
    );

    assign out_free = !r_out_valid || !i_stall;
    // bytes that end no name need no room in the result register
    assign fire     = r_in_valid && (!step_result || out_free);
    assign o_stall  = r_in_valid && !fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_state     <= STATE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_stall) begin
                r_in_valid <= i_valid;
            end
            if (fire) begin
                r_state <= n_state;
            end
            if (out_free) begin
                r_out_valid <= fire && step_result;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_in_byte  <= i_data_byte;
            r_in_last  <= i_last_byte;
            r_in_empty <= i_empty_name;
        end
        if (out_free && fire && step_result) begin
            r_out_status <= step_status;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_status = r_out_status;

endmodule
